FILE: design/opc_pkg.sv
package opc_pkg;

	localparam logic signed [15:0] ELEV_MIN   = 16'sd5461;
	localparam logic signed [15:0] ELEV_MAX   = 16'sd16384;
	localparam logic signed [17:0] RADIUS_MIN = 18'sd8192;
	localparam logic signed [17:0] RADIUS_MAX = 18'sd40960;
	localparam logic [15:0]        ELEV_RST   = 16'd5461;
	localparam logic [15:0]        RADIUS_RST = 16'd20480;

	localparam int CORDIC_STEPS = 20;
	localparam int ITER_W       = $clog2(CORDIC_STEPS);
	localparam int MUL_OPS      = 7;
	localparam int MUL_W        = $clog2(MUL_OPS);
	localparam int CNT_W        = (ITER_W > MUL_W) ? ITER_W : MUL_W;

	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

	localparam logic [1:0] CFG_TARGET_X = 2'd0;
	localparam logic [1:0] CFG_TARGET_Y = 2'd1;
	localparam logic [1:0] CFG_TARGET_Z = 2'd2;

	// multiplier schedule
	localparam logic [MUL_W-1:0] MUL_SECA  = MUL_W'(0);
	localparam logic [MUL_W-1:0] MUL_SESA  = MUL_W'(1);
	localparam logic [MUL_W-1:0] MUL_CECA  = MUL_W'(2);
	localparam logic [MUL_W-1:0] MUL_CESA  = MUL_W'(3);
	localparam logic [MUL_W-1:0] MUL_RSECA = MUL_W'(4);
	localparam logic [MUL_W-1:0] MUL_RSESA = MUL_W'(5);
	localparam logic [MUL_W-1:0] MUL_RCE   = MUL_W'(6);

	typedef struct packed {
		logic signed [15:0] delta_elevation;
		logic signed [15:0] delta_azimuth;
		logic signed [15:0] delta_radius;
	} opc_in_t;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [15:0] look_x;
		logic signed [15:0] look_y;
		logic signed [15:0] look_z;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] upv_x;
		logic signed [15:0] upv_y;
		logic signed [15:0] upv_z;
	} opc_out_t;

	typedef struct packed {
		logic              accept;
		logic              cor_init;
		logic              cor_step;
		logic [ITER_W-1:0] cor_iter;
		logic              cor_azi;
		logic              cor_save;
		logic              mul_en;
		logic [MUL_W-1:0]  mul_sel;
		logic              out_load;
	} opc_cmd_t;

	function automatic logic [31:0] cordic_atan(input logic [ITER_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'd536870912;
			5'd1:    r = 32'd316933406;
			5'd2:    r = 32'd167458907;
			5'd3:    r = 32'd85004756;
			5'd4:    r = 32'd42667331;
			5'd5:    r = 32'd21354465;
			5'd6:    r = 32'd10679838;
			5'd7:    r = 32'd5340245;
			5'd8:    r = 32'd2670163;
			5'd9:    r = 32'd1335087;
			5'd10:   r = 32'd667544;
			5'd11:   r = 32'd333772;
			5'd12:   r = 32'd166886;
			5'd13:   r = 32'd83443;
			5'd14:   r = 32'd41722;
			5'd15:   r = 32'd20861;
			5'd16:   r = 32'd10430;
			5'd17:   r = 32'd5215;
			5'd18:   r = 32'd2608;
			5'd19:   r = 32'd1304;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: design/opc_cordic.sv
module opc_cordic (
	input  logic                       clk,
	input  logic                       init,
	input  logic                       step,
	input  logic [opc_pkg::ITER_W-1:0] iter,
	input  logic [15:0]                ang,
	output logic signed [15:0]         cos_v,
	output logic signed [15:0]         sin_v
);
	import opc_pkg::*;

	logic signed [33:0] x_q, y_q, z_q;
	logic               flip_q;
	logic signed [15:0] sa;
	logic signed [15:0] sa_turn;
	logic               flip;
	logic signed [33:0] dx, dy, atab;
	logic signed [33:0] xr, yr;
	logic signed [15:0] xc, yc;

	// half-turn fold into [-pi/2, pi/2]
	assign sa      = $signed(ang);
	assign flip    = (sa > 16'sd16384) || (sa < -16'sd16384);
	assign sa_turn = flip ? $signed(ang + 16'h8000) : sa;

	assign dx   = y_q >>> iter;
	assign dy   = x_q >>> iter;
	assign atab = $signed({2'b00, cordic_atan(iter)});

	always_ff @(posedge clk) begin
		if (init) begin
			x_q    <= CORDIC_X0;
			y_q    <= '0;
			z_q    <= {{2{sa_turn[15]}}, sa_turn, 16'h0000};
			flip_q <= flip;
		end else if (step) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atab;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atab;
			end
		end
	end

	assign xr = (x_q + 34'sd32768) >>> 16;
	assign yr = (y_q + 34'sd32768) >>> 16;

	always_comb begin
		if (xr > 34'sd16384)       xc = 16'sd16384;
		else if (xr < -34'sd16384) xc = -16'sd16384;
		else                       xc = xr[15:0];
		if (yr > 34'sd16384)       yc = 16'sd16384;
		else if (yr < -34'sd16384) yc = -16'sd16384;
		else                       yc = yr[15:0];
	end

	assign cos_v = flip_q ? -xc : xc;
	assign sin_v = flip_q ? -yc : yc;

endmodule

FILE: design/opc_datapath.sv
module opc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  opc_pkg::opc_cmd_t cmd,
	input  opc_pkg::opc_in_t  in_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [19:0]       cfg_data,
	output opc_pkg::opc_out_t out_data
);
	import opc_pkg::*;

	logic signed [19:0] tx_q, ty_q, tz_q;
	logic [15:0]        elev_q, azim_q, radius_q;
	logic signed [15:0] se_q, ce_q, sa_q, ca_q;
	logic signed [47:0] prod_q [MUL_OPS];
	opc_out_t           out_q;

	logic signed [15:0] e_sum;
	logic signed [17:0] r_sum;
	logic [15:0]        e_new, r_new;
	logic signed [15:0] cor_cos, cor_sin;
	logic signed [29:0] opa, opb;
	logic signed [59:0] prod;
	opc_out_t           res;

	function automatic logic signed [47:0] rnd14(input logic signed [47:0] v);
		return (v + 48'sd8192) >>> 14;
	endfunction

	function automatic logic signed [47:0] rnd28(input logic signed [47:0] v);
		return (v + 48'sd134217728) >>> 28;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		logic signed [23:0] r;
		if (v > 48'sd8388607)       r = 24'sd8388607;
		else if (v < -48'sd8388608) r = -24'sd8388608;
		else                        r = v[23:0];
		return r;
	endfunction

	// state update: angles wrap, then elevation and radius clamp
	assign e_sum = $signed(elev_q + in_data.delta_elevation);
	assign r_sum = $signed({2'b00, radius_q}) + 18'(in_data.delta_radius);

	always_comb begin
		if (e_sum < ELEV_MIN)      e_new = ELEV_MIN;
		else if (e_sum > ELEV_MAX) e_new = ELEV_MAX;
		else                       e_new = e_sum;
		if (r_sum < RADIUS_MIN)      r_new = RADIUS_MIN[15:0];
		else if (r_sum > RADIUS_MAX) r_new = RADIUS_MAX[15:0];
		else                         r_new = r_sum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q     <= '0;
			ty_q     <= '0;
			tz_q     <= '0;
			elev_q   <= ELEV_RST;
			azim_q   <= '0;
			radius_q <= RADIUS_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TARGET_X: tx_q <= cfg_data;
					CFG_TARGET_Y: ty_q <= cfg_data;
					CFG_TARGET_Z: tz_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				elev_q   <= e_new;
				azim_q   <= azim_q + in_data.delta_azimuth;
				radius_q <= r_new;
			end
		end
	end

	opc_cordic u_cordic (
		.clk  (clk),
		.init (cmd.cor_init),
		.step (cmd.cor_step),
		.iter (cmd.cor_iter),
		.ang  (cmd.cor_azi ? azim_q : elev_q),
		.cos_v(cor_cos),
		.sin_v(cor_sin)
	);

	// single shared multiplier, one product a cycle
	always_comb begin
		case (cmd.mul_sel)
			MUL_SECA:  begin opa = 30'(se_q);               opb = 30'(ca_q); end
			MUL_SESA:  begin opa = 30'(se_q);               opb = 30'(sa_q); end
			MUL_CECA:  begin opa = 30'(ce_q);               opb = 30'(ca_q); end
			MUL_CESA:  begin opa = 30'(ce_q);               opb = 30'(sa_q); end
			MUL_RSECA: begin opa = $signed({14'd0, radius_q}); opb = prod_q[MUL_SECA][29:0]; end
			MUL_RSESA: begin opa = $signed({14'd0, radius_q}); opb = prod_q[MUL_SESA][29:0]; end
			MUL_RCE:   begin opa = $signed({14'd0, radius_q}); opb = 30'(ce_q); end
			default:   begin opa = '0;                      opb = '0; end
		endcase
	end

	assign prod = opa * opb;

	always_ff @(posedge clk) begin
		if (cmd.cor_save) begin
			if (cmd.cor_azi) begin
				ca_q <= cor_cos;
				sa_q <= cor_sin;
			end else begin
				ce_q <= cor_cos;
				se_q <= cor_sin;
			end
		end
		if (cmd.mul_en)
			prod_q[cmd.mul_sel] <= prod[47:0];
		if (cmd.out_load)
			out_q <= res;
	end

	always_comb begin
		res.pos_x   = sat24(48'(tx_q) + rnd28(prod_q[MUL_RSECA]));
		res.pos_y   = sat24(48'(ty_q) + rnd14(prod_q[MUL_RCE]));
		res.pos_z   = sat24(48'(tz_q) + rnd28(prod_q[MUL_RSESA]));
		res.look_x  = 16'(-rnd14(prod_q[MUL_SECA]));
		res.look_y  = -ce_q;
		res.look_z  = 16'(-rnd14(prod_q[MUL_SESA]));
		res.right_x = -sa_q;
		res.right_y = '0;
		res.right_z = ca_q;
		res.upv_x   = 16'(-rnd14(prod_q[MUL_CECA]));
		res.upv_y   = se_q;
		res.upv_z   = 16'(-rnd14(prod_q[MUL_CESA]));
	end

	assign out_data = out_q;

endmodule

FILE: design/opc_ctrl.sv
module opc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_stall,
	output logic              busy,
	output logic              out_valid,
	output opc_pkg::opc_cmd_t cmd
);
	import opc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ITER,
		ST_SAVE,
		ST_MUL,
		ST_DONE
	} state_t;

	localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(CORDIC_STEPS - 1);
	localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_OPS - 1);

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              azi_q;
	logic              out_valid_q;

	always_comb begin
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.cor_init = (state_q == ST_INIT);
		cmd.cor_step = (state_q == ST_ITER);
		cmd.cor_iter = cnt_q[ITER_W-1:0];
		cmd.cor_azi  = azi_q;
		cmd.cor_save = (state_q == ST_SAVE);
		cmd.mul_en   = (state_q == ST_MUL);
		cmd.mul_sel  = cnt_q[MUL_W-1:0];
		cmd.out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			azi_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// held while stalled, refilled by a load
			out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						azi_q   <= 1'b0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					if (cnt_q == ITER_LAST)
						state_q <= ST_SAVE;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_SAVE: begin
					cnt_q <= '0;
					if (azi_q) begin
						state_q <= ST_MUL;
					end else begin
						azi_q   <= 1'b1;
						state_q <= ST_INIT;
					end
				end
				ST_MUL: begin
					if (cnt_q == MUL_LAST)
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_DONE: begin
					if (cmd.out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: design/orbit_camera_pose_core.sv
// Orbit camera pose core.
// Input channel (in_valid / in_stall / in_data): one beat carries elevation,
// azimuth and radius deltas. in_stall is high while an item is in work.
// Output channel (out_valid / out_stall / out_data): one beat per input beat,
// position, look, right and up vectors. A result waits in the output
// register while out_stall is high; the next input beat is still taken and
// worked, but its result is held back until the register frees.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
// target point; cfg_ready is always high, index 3 is ignored.
// Each input beat is worked through before the next is taken: the shared
// CORDIC unit (20 steps, run once for elevation and once for azimuth),
// then the single multiplier (7 products), then the output load.
// Reset: target at origin, elevation pi/6, azimuth 0, radius 5.0, output
// register empty.
module orbit_camera_pose_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  opc_pkg::opc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output opc_pkg::opc_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [19:0]       cfg_data
);
	import opc_pkg::*;

	opc_cmd_t cmd;
	logic     busy;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;

	// sequencer: cordic passes, multiplier schedule, output load
	opc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_stall(out_stall),
		.busy     (busy),
		.out_valid(out_valid),
		.cmd      (cmd)
	);

	// angle/radius state, target, cordic, multiplier, output register
	opc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

	// once taken, the item still holds the input side at the end of the first cordic pass
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> ##20 in_stall)
		else $error("input taken during cordic pass");

	// a fresh result only follows work in progress
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	// right vector lies in the horizontal plane
	a_right_flat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.right_y == '0))
		else $error("right_y not zero");

endmodule

FILE: verif/tb_orbit_camera_pose_core.sv
module tb_orbit_camera_pose_core;
	import opc_pkg::*;

	// Clock, reset and block ports
	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	opc_in_t    in_data;
	logic       out_valid;
	logic       out_stall;
	opc_out_t   out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [19:0] cfg_data;

	orbit_camera_pose_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: a private copy of the pose and of the target registers
	logic signed [19:0] tgt_x, tgt_y, tgt_z;
	logic [15:0]        elev_ang, azim_ang, orbit_r;
	opc_out_t           pose_queue[$];
	int                 fail_count;
	int                 send_idle_pct, recv_stall_pct;

	// Directed stimulus table; known = 1 marks a row with a typed-in result
	typedef struct {
		opc_in_t  beat;
		bit       known;
		opc_out_t pose;
	} dir_row_t;
	dir_row_t dir_rows[$];

	localparam logic [1:0] CFG_UNUSED = 2'd3;

	int unsigned atan_tab[CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087,
		667544, 333772, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304};

	// Round half up: floor((v + 2^(s-1)) / 2^s); >>> floors on signed values
	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// 20-step rotation; angles beyond a quarter turn go round by half a turn
	task automatic angle_sin_cos(input logic [15:0] ang, output longint c, output longint s);
		longint sa, x, y, z, dx, dy;
		bit     flip;
		sa   = longint'($signed(ang));
		flip = 0;
		if (sa > 16384 || sa < -16384) begin
			sa   = longint'($signed(16'(ang + 16'd32768)));
			flip = 1;
		end
		x = 652032874;
		y = 0;
		z = sa * 65536;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		x = clip(round_shift(x, 16), -16384, 16384);
		y = clip(round_shift(y, 16), -16384, 16384);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// Advance the pose by one beat of deltas and return the camera frame
	task automatic predict_pose(input opc_in_t d, output opc_out_t p);
		longint e, r, se, ce, sa, ca;
		e = longint'($signed(16'(elev_ang + d.delta_elevation)));
		e = clip(e, ELEV_MIN, ELEV_MAX);
		elev_ang = 16'(e);
		azim_ang = azim_ang + d.delta_azimuth;
		r = clip(longint'(orbit_r) + longint'(d.delta_radius), RADIUS_MIN, RADIUS_MAX);
		orbit_r = 16'(r);
		angle_sin_cos(elev_ang, ce, se);
		angle_sin_cos(azim_ang, ca, sa);
		p.pos_x   = 24'(clip(tgt_x + round_shift(r * se * ca, 28), -8388608, 8388607));
		p.pos_y   = 24'(clip(tgt_y + round_shift(r * ce, 14), -8388608, 8388607));
		p.pos_z   = 24'(clip(tgt_z + round_shift(r * se * sa, 28), -8388608, 8388607));
		p.look_x  = 16'(-round_shift(se * ca, 14));
		p.look_y  = 16'(-ce);
		p.look_z  = 16'(-round_shift(se * sa, 14));
		p.right_x = 16'(-sa);
		p.right_y = '0;
		p.right_z = 16'(ca);
		p.upv_x   = 16'(-round_shift(ce * ca, 14));
		p.upv_y   = 16'(se);
		p.upv_z   = 16'(-round_shift(ce * sa, 14));
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Run limit: far above 1100 items with heavy stalling
	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Output side: random stall, compare each result beat with the oldest expectation
	always @(posedge clk) begin
		opc_out_t exp_pose;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pose_queue.size() == 0) begin
					$error("result beat with no expectation waiting");
					fail_count++;
				end else begin
					exp_pose = pose_queue.pop_front();
					if (out_data.pos_x !== exp_pose.pos_x) begin
						$error("pos_x exp %0d got %0d", exp_pose.pos_x, out_data.pos_x); fail_count++; end
					if (out_data.pos_y !== exp_pose.pos_y) begin
						$error("pos_y exp %0d got %0d", exp_pose.pos_y, out_data.pos_y); fail_count++; end
					if (out_data.pos_z !== exp_pose.pos_z) begin
						$error("pos_z exp %0d got %0d", exp_pose.pos_z, out_data.pos_z); fail_count++; end
					if (out_data.look_x !== exp_pose.look_x) begin
						$error("look_x exp %0d got %0d", exp_pose.look_x, out_data.look_x); fail_count++; end
					if (out_data.look_y !== exp_pose.look_y) begin
						$error("look_y exp %0d got %0d", exp_pose.look_y, out_data.look_y); fail_count++; end
					if (out_data.look_z !== exp_pose.look_z) begin
						$error("look_z exp %0d got %0d", exp_pose.look_z, out_data.look_z); fail_count++; end
					if (out_data.right_x !== exp_pose.right_x) begin
						$error("right_x exp %0d got %0d", exp_pose.right_x, out_data.right_x); fail_count++; end
					if (out_data.right_y !== exp_pose.right_y) begin
						$error("right_y exp %0d got %0d", exp_pose.right_y, out_data.right_y); fail_count++; end
					if (out_data.right_z !== exp_pose.right_z) begin
						$error("right_z exp %0d got %0d", exp_pose.right_z, out_data.right_z); fail_count++; end
					if (out_data.upv_x !== exp_pose.upv_x) begin
						$error("upv_x exp %0d got %0d", exp_pose.upv_x, out_data.upv_x); fail_count++; end
					if (out_data.upv_y !== exp_pose.upv_y) begin
						$error("upv_y exp %0d got %0d", exp_pose.upv_y, out_data.upv_y); fail_count++; end
					if (out_data.upv_z !== exp_pose.upv_z) begin
						$error("upv_z exp %0d got %0d", exp_pose.upv_z, out_data.upv_z); fail_count++; end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Write one target register; the predictor keeps the low 20 bits
	task automatic write_target(input logic [1:0] idx, input logic [19:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TARGET_X: tgt_x = val;
			CFG_TARGET_Y: tgt_y = val;
			CFG_TARGET_Z: tgt_z = val;
			default: ;
		endcase
	endtask

	// Send one beat after a random idle gap; expectation pushed on acceptance.
	// valid is lowered only when an idle gap starts, so it never gets two
	// drives in one step
	task automatic send_beat(input opc_in_t d, input bit known, input opc_out_t typed);
		opc_out_t p;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		do @(posedge clk); while (in_stall);
		predict_pose(d, p);
		if (known) p = typed;
		pose_queue.push_back(p);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pose_queue.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic opc_in_t beat_of(int de, int da, int dr);
		opc_in_t d;
		d.delta_elevation = 16'(de);
		d.delta_azimuth   = 16'(da);
		d.delta_radius    = 16'(dr);
		return d;
	endfunction

	// A random beat: mostly small steering moves, some full-range noise
	function automatic opc_in_t random_beat();
		if ($urandom_range(3) == 0)
			return beat_of($urandom, $urandom, $urandom);
		return beat_of($signed(16'($urandom_range(4000))) - 2000,
			$urandom_range(65535) >> $urandom_range(15),
			$signed(16'($urandom_range(8000))) - 4000);
	endfunction

	initial begin
		dir_row_t  row;
		opc_out_t  zero_pose;
		logic [19:0] tv;
		arst_n = 0; in_valid = 0; in_data = '0; out_stall = 0;
		cfg_valid = 0; cfg_index = CFG_TARGET_X; cfg_data = '0;
		fail_count = 0; send_idle_pct = 0; recv_stall_pct = 0;
		tgt_x = 0; tgt_y = 0; tgt_z = 0;
		elev_ang = ELEV_RST; azim_ang = '0; orbit_r = RADIUS_RST;
		zero_pose = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: first beat with zero deltas from reset pose (e = pi/6, a = 0, r = 5)
		row.beat = beat_of(0, 0, 0); row.known = 0; row.pose = zero_pose;
		dir_rows.push_back(row);
		// Elevation to top clamp: straight overhead, sin e = 1, cos e = 0
		row.beat = beat_of(16384, 0, 0); row.known = 1;
		row.pose = '{pos_x: 24'sd20480, pos_y: 24'sd0, pos_z: 24'sd0,
			look_x: -16'sd16384, look_y: 16'sd0, look_z: 16'sd0,
			right_x: 16'sd0, right_y: 16'sd0, right_z: 16'sd16384,
			upv_x: 16'sd0, upv_y: 16'sd16384, upv_z: 16'sd0};
		dir_rows.push_back(row);
		// Radius and elevation pushed past both limits; a wrapped elevation sum clamps low
		row.known = 0;
		row.beat = beat_of(0, 0, 32767);   dir_rows.push_back(row);
		row.beat = beat_of(0, 0, 32767);   dir_rows.push_back(row);
		row.beat = beat_of(0, 0, -32768);  dir_rows.push_back(row);
		row.beat = beat_of(0, 0, -32768);  dir_rows.push_back(row);
		row.beat = beat_of(-32768, 0, 0);  dir_rows.push_back(row);
		row.beat = beat_of(-1, 0, 0);      dir_rows.push_back(row);
		row.beat = beat_of(20000, 0, 0);   dir_rows.push_back(row);
		row.beat = beat_of(30000, 0, 0);   dir_rows.push_back(row);
		// Azimuth around each quadrant boundary and the half-turn flip
		row.beat = beat_of(0, 16384, 0);   dir_rows.push_back(row);
		row.beat = beat_of(0, 1, 0);       dir_rows.push_back(row);
		row.beat = beat_of(0, 16383, 0);   dir_rows.push_back(row);
		row.beat = beat_of(0, 16384, 0);   dir_rows.push_back(row);
		row.beat = beat_of(0, -32768, 0);  dir_rows.push_back(row);
		row.beat = beat_of(0, 32767, 0);   dir_rows.push_back(row);
		row.beat = beat_of(-1, -1, -1);    dir_rows.push_back(row);

		foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].known, dir_rows[i].pose);
		drain_results();

		// Target extremes at both ends of the 20-bit range; unused index ignored
		write_target(CFG_TARGET_X, 20'h7FFFF);
		write_target(CFG_TARGET_Y, 20'h80000);
		write_target(CFG_TARGET_Z, 20'h7FFFF);
		write_target(CFG_UNUSED,   20'hFFFFF);
		for (int i = 0; i < 8; i++) send_beat(random_beat(), 0, zero_pose);
		drain_results();
		write_target(CFG_TARGET_X, 20'h80000);
		write_target(CFG_TARGET_Y, 20'h7FFFF);
		write_target(CFG_TARGET_Z, 20'h80000);
		for (int i = 0; i < 8; i++) send_beat(random_beat(), 0, zero_pose);
		drain_results();

		// Random phases: none, sender idle, receiver stalling, both; new target each
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				3: begin send_idle_pct = 22; recv_stall_pct = 22; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			tv = $urandom; write_target(CFG_TARGET_X, tv);
			tv = $urandom; write_target(CFG_TARGET_Y, tv);
			tv = $urandom; write_target(CFG_TARGET_Z, tv);
			for (int i = 0; i < 200; i++) send_beat(random_beat(), 0, zero_pose);
			drain_results();
		end
		recv_stall_pct = 0;

		if (pose_queue.size() != 0) begin
			$error("%0d expected results never arrived", pose_queue.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
